// ----- rtl/pds_pkg.sv -----
// Shared types, codes and constants of the PWM duty-cycle to PCM sampler.
`default_nettype none

package pds_pkg;

  localparam int unsigned TIME_W     = 48;
  localparam int unsigned ACC_W      = 49;
  localparam int unsigned WIN_W      = 24;
  localparam int unsigned AMP_W      = 8;
  localparam int unsigned PROD_W     = WIN_W + AMP_W;
  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned INDEX_W    = 12;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned DIV_STEPS  = AMP_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam int unsigned S_TDATA_W  = 56;
  localparam int unsigned S_TUSER_W  = CMD_W;
  localparam int unsigned M_TDATA_W  = 32;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = WIN_W;

  localparam int unsigned RING_SAMPLES_DEF = 4096;
  localparam int unsigned PLAY_BANKS_DEF   = 4;
  localparam int unsigned BANK_SAMPLES_DEF = 512;

  localparam logic [CMD_W-1:0] CMD_LEFT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RIGHT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POLL  = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_ENABLED   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE = 2'd2;

  localparam logic             ENABLED_RST   = 1'b1;
  localparam logic [WIN_W-1:0] WINDOW_RST    = 24'd1000;
  localparam logic [AMP_W-1:0] AMPLITUDE_RST = 8'd84;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLOSE,
    ST_CLAMP,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } pds_state_t;

  typedef struct packed {
    logic capture;
    logic line_upd;
    logic wend_load;
    logic close;
    logic clamp;
    logic mul;
    logic div_step;
    logic load_out;
  } pds_cmd_t;

  typedef struct packed {
    logic             enabled;
    logic [CMD_W-1:0] command;
    logic             poll_due;
  } pds_status_t;

endpackage

`default_nettype wire

// ----- rtl/pds_ctrl.sv -----
// Sequencing state machine of the sampler: accept, update, close, clamp, multiply, divide, emit.
`default_nettype none

module pds_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  input  wire pds_pkg::pds_status_t status,
  output pds_pkg::pds_cmd_t         cmd
);

  pds_pkg::pds_state_t                state, state_next;
  logic [pds_pkg::DIV_CNT_W-1:0]      div_cnt, div_cnt_next;
  logic                               out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pds_pkg::ST_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    s_tready     = 1'b0;
    out_valid_next = out_valid && !m_tready;
    case (state)
      pds_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = pds_pkg::ST_EXEC;
        end
      end
      pds_pkg::ST_EXEC: begin
        cmd.wend_load = 1'b1;
        state_next    = pds_pkg::ST_IDLE;
        if (status.enabled) begin
          if (status.command == pds_pkg::CMD_LEFT || status.command == pds_pkg::CMD_RIGHT) begin
            cmd.line_upd = 1'b1;
          end else if (status.command == pds_pkg::CMD_POLL && status.poll_due) begin
            state_next = pds_pkg::ST_CLOSE;
          end
        end
      end
      pds_pkg::ST_CLOSE: begin
        cmd.close  = 1'b1;
        state_next = pds_pkg::ST_CLAMP;
      end
      pds_pkg::ST_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = pds_pkg::ST_MUL;
      end
      pds_pkg::ST_MUL: begin
        cmd.mul      = 1'b1;
        div_cnt_next = pds_pkg::DIV_CNT_W'(pds_pkg::DIV_STEPS - 1);
        state_next   = pds_pkg::ST_DIV;
      end
      pds_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt - 1'b1;
        if (div_cnt == '0) begin
          state_next = pds_pkg::ST_OUT;
        end
      end
      pds_pkg::ST_OUT: begin
        if (!out_valid || m_tready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = pds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pds_pkg::ST_IDLE;
      end
    endcase
  end

  assign m_tvalid = out_valid;

endmodule

`default_nettype wire

// ----- rtl/pds_datapath.sv -----
// Datapath of the sampler: config registers, line state, accumulators, divider, output word.
`default_nettype none

module pds_datapath #(
  parameter int unsigned RING_SAMPLES = pds_pkg::RING_SAMPLES_DEF,
  parameter int unsigned PLAY_BANKS   = pds_pkg::PLAY_BANKS_DEF,
  parameter int unsigned BANK_SAMPLES = pds_pkg::BANK_SAMPLES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [pds_pkg::S_TDATA_W-1:0]   s_tdata,
  input  wire logic [pds_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic      [pds_pkg::M_TDATA_W-1:0]   m_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [pds_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [pds_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire pds_pkg::pds_cmd_t               cmd,
  output pds_pkg::pds_status_t                 status
);

  localparam int unsigned PTR_W   = $clog2(RING_SAMPLES);
  localparam int unsigned PTR_RST = (PLAY_BANKS * BANK_SAMPLES) % RING_SAMPLES;
  localparam int unsigned TW = pds_pkg::TIME_W;
  localparam int unsigned AW = pds_pkg::ACC_W;
  localparam int unsigned WW = pds_pkg::WIN_W;
  localparam int unsigned MW = pds_pkg::AMP_W;
  localparam int unsigned SW = pds_pkg::SAMPLE_W;

  localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

  function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] acc,
                                                   input logic signed [AW:0]   d);
    logic signed [AW:0] s;
    s = {acc[AW-1], acc} + d;
    case (s[AW:AW-1])
      2'b01:   sat_add = ACC_MAX;
      2'b10:   sat_add = ACC_MIN;
      default: sat_add = s[AW-1:0];
    endcase
  endfunction

  function automatic logic [WW-1:0] clamp_high(input logic signed [AW-1:0] acc,
                                               input logic [WW-1:0]        win);
    if (acc[AW-1]) begin
      clamp_high = '0;
    end else if (acc > $signed({{(AW-WW){1'b0}}, win})) begin
      clamp_high = win;
    end else begin
      clamp_high = acc[WW-1:0];
    end
  endfunction

  logic                          enabled;
  logic [WW-1:0]                 window_ticks;
  logic [MW-1:0]                 amplitude;
  logic                          left_high, right_high;
  logic [TW-1:0]                 left_edge, right_edge;
  logic signed [AW-1:0]          left_acc, right_acc;
  logic [TW-1:0]                 window_start;
  logic [PTR_W-1:0]              wptr;

  logic [pds_pkg::CMD_W-1:0]     cmd_r;
  logic                          level_r;
  logic [TW-1:0]                 now_r;
  logic [TW:0]                   wend;
  logic [WW-1:0]                 h_l, h_r;
  logic [WW-1:0]                 rem_l, rem_r;
  logic [MW-1:0]                 lo_l, lo_r;
  logic [MW-1:0]                 quo_l, quo_r;
  logic [pds_pkg::INDEX_W-1:0]   idx_r;
  logic                          resync_r;

  logic [WW-1:0]                 win_eff;
  logic [TW:0]                   wend_comb;
  logic signed [AW:0]            line_d_l, line_d_r, close_d_l, close_d_r;
  logic [pds_pkg::PROD_W-1:0]    prod_l, prod_r;
  logic [WW:0]                   t_l, t_r;
  logic                          ge_l, ge_r;
  logic [TW+1:0]                 lag_end;
  logic [MW-1:0]                 offset;
  logic [SW:0]                   sum_l, sum_r;
  logic [SW-1:0]                 smp_l, smp_r;
  logic [PTR_W-1:0]              wptr_next;

  assign win_eff   = (window_ticks == '0) ? WW'(1) : window_ticks;
  assign wend_comb = {1'b0, window_start} + {{(TW+1-WW){1'b0}}, win_eff};
  assign line_d_l  = $signed({2'b00, now_r} - {2'b00, left_edge});
  assign line_d_r  = $signed({2'b00, now_r} - {2'b00, right_edge});
  assign close_d_l = $signed({1'b0, wend} - {2'b00, left_edge});
  assign close_d_r = $signed({1'b0, wend} - {2'b00, right_edge});
  assign prod_l    = {{MW{1'b0}}, h_l} * {{WW{1'b0}}, amplitude};
  assign prod_r    = {{MW{1'b0}}, h_r} * {{WW{1'b0}}, amplitude};
  assign t_l       = {rem_l, lo_l[MW-1]};
  assign t_r       = {rem_r, lo_r[MW-1]};
  assign ge_l      = t_l >= {1'b0, win_eff};
  assign ge_r      = t_r >= {1'b0, win_eff};
  assign lag_end   = {2'b00, window_start} + {{(TW+1-WW){1'b0}}, win_eff, 1'b0};
  assign offset    = (MW'(255) - amplitude) >> 1;
  assign sum_l     = {1'b0, offset} + {1'b0, quo_l};
  assign sum_r     = {1'b0, offset} + {1'b0, quo_r};
  assign smp_l     = sum_l[SW] ? {SW{1'b1}} : sum_l[SW-1:0];
  assign smp_r     = sum_r[SW] ? {SW{1'b1}} : sum_r[SW-1:0];
  assign wptr_next = (wptr == PTR_W'(RING_SAMPLES - 1)) ? '0 : wptr + 1'b1;

  assign status.enabled  = enabled;
  assign status.command  = cmd_r;
  assign status.poll_due = {1'b0, now_r} >= wend_comb;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled      <= pds_pkg::ENABLED_RST;
      window_ticks <= pds_pkg::WINDOW_RST;
      amplitude    <= pds_pkg::AMPLITUDE_RST;
      left_high    <= 1'b0;
      right_high   <= 1'b0;
      left_edge    <= '0;
      right_edge   <= '0;
      left_acc     <= '0;
      right_acc    <= '0;
      window_start <= '0;
      wptr         <= PTR_W'(PTR_RST);
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          pds_pkg::REG_ENABLED:   enabled      <= cfg_wdata[0];
          pds_pkg::REG_WINDOW:    window_ticks <= cfg_wdata[WW-1:0];
          pds_pkg::REG_AMPLITUDE: amplitude    <= cfg_wdata[MW-1:0];
          default: ;
        endcase
      end
      if (cmd.line_upd) begin
        if (cmd_r == pds_pkg::CMD_LEFT) begin
          left_high <= level_r;
          if (level_r) begin
            left_edge <= now_r;
          end else begin
            left_acc <= sat_add(left_acc, line_d_l);
          end
        end else begin
          right_high <= level_r;
          if (level_r) begin
            right_edge <= now_r;
          end else begin
            right_acc <= sat_add(right_acc, line_d_r);
          end
        end
      end
      if (cmd.close) begin
        if (left_high && wend > {1'b0, left_edge}) begin
          left_acc  <= sat_add(left_acc, close_d_l);
          left_edge <= wend[TW-1:0];
        end
        if (right_high && wend > {1'b0, right_edge}) begin
          right_acc  <= sat_add(right_acc, close_d_r);
          right_edge <= wend[TW-1:0];
        end
      end
      if (cmd.clamp) begin
        left_acc     <= '0;
        right_acc    <= '0;
        window_start <= wend[TW] ? {TW{1'b1}} : wend[TW-1:0];
        wptr         <= wptr_next;
      end
      if (cmd.mul && lag_end < {2'b00, now_r}) begin
        window_start <= now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= s_tuser;
      level_r <= s_tdata[0];
      now_r   <= s_tdata[TW:1];
    end
    if (cmd.wend_load) begin
      wend <= wend_comb;
    end
    if (cmd.clamp) begin
      h_l   <= clamp_high(left_acc, win_eff);
      h_r   <= clamp_high(right_acc, win_eff);
      idx_r <= pds_pkg::INDEX_W'(wptr);
    end
    if (cmd.mul) begin
      rem_l    <= prod_l[pds_pkg::PROD_W-1:MW];
      lo_l     <= prod_l[MW-1:0];
      rem_r    <= prod_r[pds_pkg::PROD_W-1:MW];
      lo_r     <= prod_r[MW-1:0];
      resync_r <= lag_end < {2'b00, now_r};
    end
    if (cmd.div_step) begin
      rem_l <= ge_l ? WW'(t_l - {1'b0, win_eff}) : t_l[WW-1:0];
      lo_l  <= {lo_l[MW-2:0], 1'b0};
      quo_l <= {quo_l[MW-2:0], ge_l};
      rem_r <= ge_r ? WW'(t_r - {1'b0, win_eff}) : t_r[WW-1:0];
      lo_r  <= {lo_r[MW-2:0], 1'b0};
      quo_r <= {quo_r[MW-2:0], ge_r};
    end
    if (cmd.load_out) begin
      m_tdata <= {3'b000, resync_r, idx_r, smp_r, smp_l};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pwm_duty_to_pcm_sampler.sv -----
// Top level of the PWM duty-cycle to PCM sampler: controller plus datapath.
//
// Input stream: one word per line change or sample poll. tuser carries the
// command (left change, right change, poll); tdata carries the new level and
// the 48-bit tick time. Output stream: one stereo PCM word for each poll that
// closes a sample window; polls before the window end and all words while
// disabled give nothing.
// One word is in work at a time. A line change passes the execute state and
// returns to ready; a poll that closes a window steps through close, clamp,
// multiply, the 8-step restoring divider that scales the high time by the
// window length, and the output load.
// The result sits in an output register, so the next input word is taken
// while it waits; a poll finishing while that register is still full holds
// in its last step until the receiver takes the old word.
// Reset (synchronous, active high) restores register defaults, clears line
// state and accumulators, and drops any pending output word.
// Configuration writes (enable, window ticks, amplitude) take effect at once;
// the user must make them only while no word is in work, as the block does not enforce it.
`default_nettype none

module pwm_duty_to_pcm_sampler #(
  parameter int unsigned RING_SAMPLES = pds_pkg::RING_SAMPLES_DEF,
  parameter int unsigned PLAY_BANKS   = pds_pkg::PLAY_BANKS_DEF,
  parameter int unsigned BANK_SAMPLES = pds_pkg::BANK_SAMPLES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [0] level, [48:1] now, [55:49] zero
  input  wire logic [pds_pkg::S_TDATA_W-1:0]   s_tdata,
  // [1:0] command
  input  wire logic [pds_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [7:0] left_sample, [15:8] right_sample, [27:16] write_index, [28] resynced, [31:29] zero
  output logic      [pds_pkg::M_TDATA_W-1:0]   m_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [pds_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [pds_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  pds_pkg::pds_cmd_t    cmd;
  pds_pkg::pds_status_t status;

  pds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pds_datapath #(
    .RING_SAMPLES (RING_SAMPLES),
    .PLAY_BANKS   (PLAY_BANKS),
    .BANK_SAMPLES (BANK_SAMPLES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

// ----- rtl/pds_checker.sv -----
// Port-level checks of the sampler and their binding to the top level.
`default_nettype none

module pds_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [pds_pkg::M_TDATA_W-1:0] m_tdata
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid after reset");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a word is in work");

  a_out_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("output word appeared without a poll in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word dropped or changed");

endmodule

bind pwm_duty_to_pcm_sampler pds_checker u_pds_checker (.*);

`default_nettype wire

// ----- test/pwm_duty_to_pcm_sampler_tb.sv -----
// Self-checking testbench for the PWM duty-cycle to PCM sampler, stream in and out.
`default_nettype none

module pwm_duty_to_pcm_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pds_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] TIME_TOP = 48'hFFFF_FFFF_FFFF;
  localparam longint ACC_TOP = 64'sh0000_FFFF_FFFF_FFFF;
  localparam longint ACC_BOTTOM = -ACC_TOP - 1;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned SINK_HOLD_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_WORDS = 50;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic [INDEX_W-1:0]  index;
    logic                resynced;
  } pcm_word_t;

  typedef enum logic {ROW_WORD, ROW_SETUP} plan_kind_t;

  typedef struct packed {
    plan_kind_t         kind;
    logic [CMD_W-1:0]   cmd;
    logic               lvl;
    logic [TIME_W-1:0]  now;
    logic               en;
    logic [WIN_W-1:0]   win;
    logic [AMP_W-1:0]   amp;
    logic               fixed;
    pcm_word_t          want;
  } plan_row_t;

  localparam pcm_word_t NO_WORD = '0;

  localparam plan_row_t PLAN [26] = '{
    '{ROW_WORD,  CMD_POLL,   1'b0, 48'd999,      1'b0, 24'd0, 8'd0, 1'b0, NO_WORD},
    '{ROW_WORD,  CMD_POLL,   1'b1, 48'd1000,     1'b0, 24'd0, 8'd0, 1'b1,
      '{8'd85, 8'd85, 12'd2048, 1'b0}},
    '{ROW_WORD,  CMD_LEFT,   1'b1, 48'd1000,     1'b0, 24'd0, 8'd0, 1'b0, NO_WORD},
    '{ROW_WORD,  CMD_RIGHT,  1'b1, 48'd1200,     1'b0, 24'd0, 8'd0, 1'b0, NO_WORD},
    '{ROW_WORD,  CMD_LEFT,   1'b0, 48'd1500,     1'b0, 24'd0, 8'd0, 1'b0, NO_WORD},
    '{ROW_WORD,  CMD_UNUSED, 1'b1, 48'd1600,     1'b0, 24'd0, 8'd0, 1'b0, NO_WORD},
    '{ROW_WORD,  CMD_POLL,   1'b0, 48'd2000,     1'b0, 24'd0, 8'd0, 1'b0, NO_WORD},
    '{ROW_WORD,  CMD_RIGHT,  1'b0, 48'd2500,     1'b0, 24'd0, 8'd0, 1'b0, NO_WORD},
    '{ROW_WORD,  CMD_RIGHT,  1'b0, 48'd2600,     1'b0, 24'd0, 8'd0, 1'b0, NO_WORD},
    '{ROW_WORD,  CMD_POLL,   1'b1, 48'd3000,     1'b0, 24'd0, 8'd0, 1'b0, NO_WORD},
    '{ROW_SETUP, CMD_LEFT,   1'b0, 48'd0,        1'b1, 24'd0, 8'd255, 1'b0, NO_WORD},
    '{ROW_WORD,  CMD_LEFT,   1'b1, 48'd3000,     1'b0, 24'd0, 8'd0, 1'b0, NO_WORD},
    '{ROW_WORD,  CMD_POLL,   1'b0, 48'd3001,     1'b0, 24'd0, 8'd0, 1'b1,
      '{8'd255, 8'd0, 12'd2051, 1'b0}},
    '{ROW_WORD,  CMD_LEFT,   1'b0, 48'd0,        1'b0, 24'd0, 8'd0, 1'b0, NO_WORD},
    '{ROW_WORD,  CMD_LEFT,   1'b1, TIME_TOP,     1'b0, 24'd0, 8'd0, 1'b0, NO_WORD},
    '{ROW_WORD,  CMD_LEFT,   1'b0, 48'd0,        1'b0, 24'd0, 8'd0, 1'b0, NO_WORD},
    '{ROW_SETUP, CMD_LEFT,   1'b0, 48'd0,        1'b1, 24'hFF_FFFF, 8'd0, 1'b0, NO_WORD},
    '{ROW_WORD,  CMD_POLL,   1'b0, 48'd16780216, 1'b0, 24'd0, 8'd0, 1'b1,
      '{8'd127, 8'd127, 12'd2052, 1'b0}},
    '{ROW_WORD,  CMD_RIGHT,  1'b1, 48'd0,        1'b0, 24'd0, 8'd0, 1'b0, NO_WORD},
    '{ROW_WORD,  CMD_RIGHT,  1'b0, TIME_TOP,     1'b0, 24'd0, 8'd0, 1'b0, NO_WORD},
    '{ROW_WORD,  CMD_RIGHT,  1'b0, TIME_TOP,     1'b0, 24'd0, 8'd0, 1'b0, NO_WORD},
    '{ROW_SETUP, CMD_LEFT,   1'b0, 48'd0,        1'b0, 24'd1000, 8'd84, 1'b0, NO_WORD},
    '{ROW_WORD,  CMD_LEFT,   1'b1, TIME_TOP,     1'b0, 24'd0, 8'd0, 1'b0, NO_WORD},
    '{ROW_WORD,  CMD_POLL,   1'b1, TIME_TOP,     1'b0, 24'd0, 8'd0, 1'b0, NO_WORD},
    '{ROW_SETUP, CMD_LEFT,   1'b0, 48'd0,        1'b1, 24'd7, 8'd200, 1'b0, NO_WORD},
    '{ROW_WORD,  CMD_POLL,   1'b0, 48'hAAAA_AAAA_AAAA, 1'b0, 24'd0, 8'd0, 1'b0, NO_WORD}
  };

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [S_TUSER_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic cfg_on;
  int unsigned cfg_window;
  int unsigned cfg_amp;
  logic ln_high [2];
  longint unsigned edge_at [2];
  longint acc_ticks [2];
  longint unsigned win_start;
  int unsigned wr_ptr;

  pcm_word_t pcm_expected [$];
  pcm_word_t oldest;
  int unsigned sample_errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned src_gap_pct = 0;
  int unsigned sink_stall_pct = 0;
  bit sink_hold_req = 1'b0;
  logic [TIME_W-1:0] stream_time;

  pwm_duty_to_pcm_sampler uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void reset_sampler_model();
    cfg_on = ENABLED_RST;
    cfg_window = WINDOW_RST;
    cfg_amp = AMPLITUDE_RST;
    for (int c = 0; c < 2; c++) begin
      ln_high[c] = 1'b0;
      edge_at[c] = 0;
      acc_ticks[c] = 0;
    end
    win_start = 0;
    wr_ptr = (PLAY_BANKS_DEF * BANK_SAMPLES_DEF) % RING_SAMPLES_DEF;
  endfunction

  function automatic longint clip_ticks(longint total, longint delta);
    longint s;
    s = total + delta;
    if (s > ACC_TOP) return ACC_TOP;
    if (s < ACC_BOTTOM) return ACC_BOTTOM;
    return s;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pcm_level(longint high_ticks, longint unsigned w);
    longint unsigned h;
    longint unsigned v;
    if (high_ticks < 0) h = 0;
    else h = high_ticks;
    if (h > w) h = w;
    v = (255 - cfg_amp) / 2 + h * cfg_amp / w;
    if (v > 255) v = 255;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic bit predict_pcm(input logic [CMD_W-1:0] cmd, input logic lvl,
                                     input logic [TIME_W-1:0] at, output pcm_word_t res);
    int ch;
    longint unsigned w;
    longint unsigned wend;
    res = '0;
    if (!cfg_on) return 1'b0;
    case (cmd)
      CMD_LEFT, CMD_RIGHT: begin
        ch = (cmd == CMD_RIGHT) ? 1 : 0;
        if (lvl) edge_at[ch] = at;
        else acc_ticks[ch] = clip_ticks(acc_ticks[ch], longint'(at) - longint'(edge_at[ch]));
        ln_high[ch] = lvl;
        return 1'b0;
      end
      CMD_POLL: begin
        w = (cfg_window == 0) ? 1 : cfg_window;
        wend = win_start + w;
        if (at < wend) return 1'b0;
        for (int c = 1; c >= 0; c--) begin
          if (ln_high[c] && wend > edge_at[c]) begin
            acc_ticks[c] = clip_ticks(acc_ticks[c], longint'(wend - edge_at[c]));
            edge_at[c] = wend;
          end
        end
        res.left = pcm_level(acc_ticks[0], w);
        res.right = pcm_level(acc_ticks[1], w);
        res.index = wr_ptr[INDEX_W-1:0];
        wr_ptr = (wr_ptr + 1) % RING_SAMPLES_DEF;
        acc_ticks[0] = 0;
        acc_ticks[1] = 0;
        win_start = (wend > TIME_TOP) ? TIME_TOP : wend;
        if (win_start + 2 * w < at) begin
          win_start = at;
          res.resynced = 1'b1;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic lvl,
                           input logic [TIME_W-1:0] at, input logic fixed,
                           input pcm_word_t want);
    pcm_word_t res;
    bit has;
    if ($urandom_range(0, 99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_gap_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {7'b0, at, lvl};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    has = predict_pcm(cmd, lvl, at, res);
    if (fixed) res = want;
    if (has || fixed) pcm_expected.push_back(res);
  endtask

  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (pcm_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(input logic en, input logic [WIN_W-1:0] win,
                                input logic [AMP_W-1:0] amp);
    cfg_we <= 1'b1;
    cfg_addr <= REG_ENABLED;
    cfg_wdata <= CFG_DATA_W'(en);
    @(posedge clk);
    cfg_addr <= REG_WINDOW;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_addr <= REG_AMPLITUDE;
    cfg_wdata <= CFG_DATA_W'(amp);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_on = en;
    cfg_window = win;
    cfg_amp = amp;
  endtask

  task automatic offer_random_word(output bit counted);
    logic [CMD_W-1:0] cmd;
    logic lvl;
    logic [TIME_W-1:0] at;
    longint unsigned aim;
    int unsigned w;
    int unsigned pick;
    bit wild;
    w = (cfg_window == 0) ? 1 : cfg_window;
    wild = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 4) cmd = CMD_UNUSED;
    else if (pick < 38) cmd = CMD_LEFT;
    else if (pick < 72) cmd = CMD_RIGHT;
    else cmd = CMD_POLL;
    lvl = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (cmd == CMD_POLL) begin
      aim = win_start + w;
      if (pick < 15) aim = aim - 1 - $urandom_range(0, w - 1);
      else if (pick < 25) aim = aim + 2 * w + 1 + $urandom_range(0, 3 * w);
      else aim = aim + $urandom_range(0, w / 4);
      at = (aim > stream_time) ? aim[TIME_W-1:0] : stream_time;
    end else if (pick < 3) begin
      at = TIME_W'({$urandom, $urandom});
      wild = 1'b1;
    end else if (pick < 6) begin
      at = stream_time - $urandom_range(0, w);
      wild = 1'b1;
    end else begin
      at = stream_time + $urandom_range(0, w / 3 + 1);
    end
    if (!wild && at > stream_time) stream_time = at;
    send_word(cmd, lvl, at, 1'b0, NO_WORD);
    counted = (cmd != CMD_UNUSED);
  endtask

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        hold_left = SINK_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pcm_expected.size() == 0) begin
        $error("unexpected sample word %h", m_tdata);
        sample_errors++;
      end else begin
        oldest = pcm_expected.pop_front();
        if (m_tdata[7:0] !== oldest.left) begin
          $error("left_sample: expected %0d, got %0d", oldest.left, m_tdata[7:0]);
          sample_errors++;
        end
        if (m_tdata[15:8] !== oldest.right) begin
          $error("right_sample: expected %0d, got %0d", oldest.right, m_tdata[15:8]);
          sample_errors++;
        end
        if (m_tdata[27:16] !== oldest.index) begin
          $error("write_index: expected %0d, got %0d", oldest.index, m_tdata[27:16]);
          sample_errors++;
        end
        if (m_tdata[28] !== oldest.resynced) begin
          $error("resynced: expected %0d, got %0d", oldest.resynced, m_tdata[28]);
          sample_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit counted;
    int unsigned done;
    logic [WIN_W-1:0] pw;
    logic [AMP_W-1:0] pa;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    reset_sampler_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < $size(PLAN); i++) begin
      if (PLAN[i].kind == ROW_SETUP) begin
        drain_pipeline();
        write_settings(PLAN[i].en, PLAN[i].win, PLAN[i].amp);
      end else begin
        send_word(PLAN[i].cmd, PLAN[i].lvl, PLAN[i].now, PLAN[i].fixed, PLAN[i].want);
      end
    end

    stream_time = win_start[TIME_W-1:0];
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_pipeline();
      case (phase % 4)
        0: begin
          src_gap_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_gap_pct = 55;
          sink_stall_pct = 0;
        end
        2: begin
          src_gap_pct = 0;
          sink_stall_pct = 55;
        end
        default: begin
          src_gap_pct = 6;
          sink_stall_pct = 6;
        end
      endcase
      pa = AMP_W'($urandom_range(0, 255));
      case (phase)
        0: begin
          pw = 24'd1;
          pa = 8'd255;
        end
        1: pw = WIN_W'($urandom_range(2, 64));
        2: pw = 24'hFF_FFFF;
        3: begin
          pw = 24'd0;
          pa = 8'd0;
        end
        default: begin
          if ($urandom_range(0, 3) == 0) pw = WIN_W'($urandom_range(1, 24'hFF_FFFF));
          else pw = WIN_W'($urandom_range(1, 300));
        end
      endcase
      if (phase == 5) begin
        write_settings(1'b0, pw, pa);
        repeat (8) offer_random_word(counted);
        drain_pipeline();
      end
      write_settings(1'b1, pw, pa);
      if (phase == 4) sink_hold_req = 1'b1;
      done = 0;
      while (done < PHASE_WORDS) begin
        if (phase == 6 && done == PHASE_WORDS / 2) drain_pipeline();
        offer_random_word(counted);
        if (counted) done++;
      end
    end

    drain_pipeline();
    if (sample_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/pds_pkg.sv
rtl/pds_ctrl.sv
rtl/pds_datapath.sv
rtl/pwm_duty_to_pcm_sampler.sv
rtl/pds_checker.sv
test/pwm_duty_to_pcm_sampler_tb.sv
